### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the top-level RTL file. Defining
// NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// When a holds, b must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// When a holds, b must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rstn, a, b)
`define ASSERT_NEXT(label, clk, rstn, a, b)

`endif

`endif

### hw/rtl/kptm_pkg.sv
// ----------------------------------------------------------------------------
// kptm_pkg
// Constants, codes and shared types of the key policy table.
// ----------------------------------------------------------------------------
`default_nettype none

package kptm_pkg;

    localparam int TABLE_DEPTH   = 32;
    localparam int KEY_ID_WORDS  = 1;
    localparam int MEASURE_WORDS = 4;
    localparam int KEY_WORDS     = 4;
    localparam int NONCE_WORDS   = 2;
    localparam int HMAC_WORDS    = 4;

    localparam int WORD_W   = 64;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 5;

    localparam int ADD_LEN   = KEY_ID_WORDS + MEASURE_WORDS + KEY_WORDS;
    localparam int MATCH_LEN = KEY_ID_WORDS + NONCE_WORDS + MEASURE_WORDS + HMAC_WORDS;
    localparam int MAX_LEN   = (ADD_LEN > MATCH_LEN) ? ADD_LEN : MATCH_LEN;

    // Words compared per entry during a search: key id followed by measure.
    localparam int CMP_WORDS = KEY_ID_WORDS + MEASURE_WORDS;
    localparam int MEAS_POS  = KEY_ID_WORDS + NONCE_WORDS;
    localparam int HMAC_POS  = MEAS_POS + MEASURE_WORDS;

    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int ENTRY_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MWORD_W = $clog2(CMP_WORDS);
    localparam int KWORD_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int MADDR_W = ENTRY_W + MWORD_W;
    localparam int KADDR_W = ENTRY_W + KWORD_W;

    localparam int S_TDATA_W = WORD_W;
    localparam int M_TDATA_W = ((INDEX_W + WORD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - INDEX_W - WORD_W;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_MATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED    = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_BAD_ATT  = 3'd2,
        STAT_NO_MATCH = 3'd3,
        STAT_MATCH    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SR_IDLE,
        SR_SCAN,
        SR_RESULT,
        SR_KEY_RD,
        SR_KEY_WR
    } sr_state_t;

    typedef logic [CMP_WORDS-1:0][WORD_W-1:0] req_words_t;

    // End of a request, raised in the cycle its last word is transferred.
    typedef struct packed {
        logic               valid;
        logic               is_match;
        logic               att_ok;
        logic               full;
        logic [ENTRY_W-1:0] entry;
    } fin_t;

    // Flow control from the search side back to the request side.
    typedef struct packed {
        logic idle;
        logic out_free;
    } ctl_t;

endpackage

`default_nettype wire

### hw/rtl/kptm_ram.sv
// ----------------------------------------------------------------------------
// kptm_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kptm_ram #(
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kptm_ingest.sv
// ----------------------------------------------------------------------------
// kptm_ingest
// Assembles request words: writes add requests straight into the table
// memories, keeps the compare words of a match request and checks its hmac.
// ----------------------------------------------------------------------------
`default_nettype none

module kptm_ingest (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic                            s_action,
    input  wire logic [kptm_pkg::WORD_W-1:0]     s_word,
    input  wire kptm_pkg::ctl_t                  ctl,
    output kptm_pkg::fin_t                       fin,
    output logic      [kptm_pkg::COUNT_W-1:0]    entry_count,
    output kptm_pkg::req_words_t                 req_words,
    output logic                                 mwr_en,
    output logic      [kptm_pkg::MADDR_W-1:0]    mwr_addr,
    output logic                                 kwr_en,
    output logic      [kptm_pkg::KADDR_W-1:0]    kwr_addr,
    output logic      [kptm_pkg::WORD_W-1:0]     wr_data
);

    logic [kptm_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         kind_reg, kind_next;
    logic                         att_reg, att_next;
    logic [kptm_pkg::COUNT_W-1:0] count_reg, count_next;
    kptm_pkg::req_words_t         req_words_reg;

    logic                         accept;
    logic                         kind_cur;
    logic [kptm_pkg::POS_W-1:0]   last_pos;
    logic                         is_last;
    logic                         last_pending;
    logic                         full;
    logic                         att_final;
    logic                         add_wr;
    logic [kptm_pkg::ENTRY_W-1:0] entry_ptr;

    // A first word never ends a request, so readiness need not look at
    // the action bit of the word on offer.
    assign last_pending = (pos_reg != '0) &&
        (pos_reg == ((kind_reg == kptm_pkg::ACT_MATCH) ?
                     kptm_pkg::POS_W'(kptm_pkg::MATCH_LEN - 1) :
                     kptm_pkg::POS_W'(kptm_pkg::ADD_LEN - 1)));
    assign s_tready = ctl.idle && (!last_pending || ctl.out_free);
    assign accept   = s_tvalid && s_tready;

    assign kind_cur = (pos_reg == '0) ? s_action : kind_reg;
    assign last_pos = (kind_cur == kptm_pkg::ACT_MATCH) ?
                      kptm_pkg::POS_W'(kptm_pkg::MATCH_LEN - 1) :
                      kptm_pkg::POS_W'(kptm_pkg::ADD_LEN - 1);
    assign is_last  = (pos_reg == last_pos);
    assign full     = (count_reg == kptm_pkg::COUNT_W'(kptm_pkg::TABLE_DEPTH));
    assign entry_ptr = count_reg[kptm_pkg::ENTRY_W-1:0];

    always_comb begin
        att_final = (pos_reg == '0) ? 1'b1 : att_reg;
        if (kind_cur == kptm_pkg::ACT_MATCH &&
            pos_reg >= kptm_pkg::POS_W'(kptm_pkg::HMAC_POS) && s_word != '0) begin
            att_final = 1'b0;
        end
    end

    // Add words go to the slot after the last valid entry; the slot only
    // counts once the whole request has arrived.
    assign add_wr   = accept && (kind_cur == kptm_pkg::ACT_ADD) && !full;
    assign mwr_en   = add_wr && (pos_reg < kptm_pkg::POS_W'(kptm_pkg::CMP_WORDS));
    assign kwr_en   = add_wr && (pos_reg >= kptm_pkg::POS_W'(kptm_pkg::CMP_WORDS));
    assign mwr_addr = {entry_ptr, kptm_pkg::MWORD_W'(pos_reg)};
    assign kwr_addr = {entry_ptr,
                       kptm_pkg::KWORD_W'(pos_reg - kptm_pkg::POS_W'(kptm_pkg::CMP_WORDS))};
    assign wr_data  = s_word;

    always_comb begin
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        att_next   = att_reg;
        count_next = count_reg;
        if (accept) begin
            pos_next  = is_last ? '0 : pos_reg + 1'b1;
            kind_next = kind_cur;
            att_next  = att_final;
            if (is_last && kind_cur == kptm_pkg::ACT_ADD && !full) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            kind_reg  <= kptm_pkg::ACT_ADD;
            att_reg   <= 1'b1;
            count_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            att_reg   <= att_next;
            count_reg <= count_next;
        end
    end

    // Key id and measure of a match request, packed as the table stores them.
    always_ff @(posedge aclk) begin
        if (accept && kind_cur == kptm_pkg::ACT_MATCH) begin
            if (pos_reg < kptm_pkg::POS_W'(kptm_pkg::KEY_ID_WORDS)) begin
                req_words_reg[kptm_pkg::MWORD_W'(pos_reg)] <= s_word;
            end else if (pos_reg >= kptm_pkg::POS_W'(kptm_pkg::MEAS_POS) &&
                         pos_reg < kptm_pkg::POS_W'(kptm_pkg::HMAC_POS)) begin
                req_words_reg[kptm_pkg::MWORD_W'(
                    pos_reg - kptm_pkg::POS_W'(kptm_pkg::NONCE_WORDS))] <= s_word;
            end
        end
    end

    assign req_words    = req_words_reg;
    assign entry_count  = count_reg;
    assign fin.valid    = accept && is_last;
    assign fin.is_match = (kind_cur == kptm_pkg::ACT_MATCH);
    assign fin.att_ok   = att_final;
    assign fin.full     = full;
    assign fin.entry    = entry_ptr;

endmodule

`default_nettype wire

### hw/rtl/kptm_search.sv
// ----------------------------------------------------------------------------
// kptm_search
// Walks the match memory for the first equal entry, reads out its key and
// holds the result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kptm_search (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire kptm_pkg::fin_t                  fin,
    input  wire logic [kptm_pkg::COUNT_W-1:0]    entry_count,
    input  wire kptm_pkg::req_words_t            req_words,
    output logic                                 mrd_en,
    output logic      [kptm_pkg::MADDR_W-1:0]    mrd_addr,
    input  wire logic [kptm_pkg::WORD_W-1:0]     mrd_data,
    output logic                                 krd_en,
    output logic      [kptm_pkg::KADDR_W-1:0]    krd_addr,
    input  wire logic [kptm_pkg::WORD_W-1:0]     krd_data,
    output kptm_pkg::ctl_t                       ctl,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output kptm_pkg::status_t                    m_status,
    output logic      [kptm_pkg::INDEX_W-1:0]    m_index,
    output logic      [kptm_pkg::WORD_W-1:0]     m_key,
    output logic                                 m_last
);

    kptm_pkg::sr_state_t          state_reg, state_next;

    logic [kptm_pkg::ENTRY_W-1:0] scan_entry_reg, scan_entry_next;
    logic [kptm_pkg::MWORD_W-1:0] scan_word_reg, scan_word_next;
    logic                         issue_on_reg, issue_on_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic [kptm_pkg::ENTRY_W-1:0] cmp_entry_reg, cmp_entry_next;
    logic [kptm_pkg::MWORD_W-1:0] cmp_word_reg, cmp_word_next;
    logic                         cmp_final_reg, cmp_final_next;
    logic                         same_reg, same_next;
    logic [kptm_pkg::ENTRY_W-1:0] match_entry_reg, match_entry_next;
    logic [kptm_pkg::KWORD_W-1:0] key_idx_reg, key_idx_next;

    logic                         m_valid_reg, m_valid_next;
    kptm_pkg::status_t            m_status_reg, m_status_next;
    logic [kptm_pkg::INDEX_W-1:0] m_index_reg, m_index_next;
    logic [kptm_pkg::WORD_W-1:0]  m_key_reg, m_key_next;
    logic                         m_last_reg, m_last_next;

    logic out_free;
    logic start_scan;
    logic same_now;
    logic entry_done;
    logic hit;
    logic miss_all;
    logic scan_last_entry;
    logic key_last;

    assign out_free   = !m_valid_reg || m_tready;
    assign start_scan = fin.valid && fin.is_match && fin.att_ok && (entry_count != '0);
    assign key_last   = (key_idx_reg == kptm_pkg::KWORD_W'(kptm_pkg::KEY_WORDS - 1));
    assign scan_last_entry =
        (kptm_pkg::COUNT_W'(scan_entry_reg) + kptm_pkg::COUNT_W'(1)) == entry_count;

    // Compare stage: the memory word read last cycle against the request.
    always_comb begin
        same_now   = (mrd_data == req_words[cmp_word_reg]) &&
                     ((cmp_word_reg == '0) || same_reg);
        entry_done = cmp_valid_reg &&
                     (cmp_word_reg == kptm_pkg::MWORD_W'(kptm_pkg::CMP_WORDS - 1));
        hit        = entry_done && same_now;
        miss_all   = entry_done && !same_now && cmp_final_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kptm_pkg::SR_IDLE: begin
                if (start_scan) begin
                    state_next = kptm_pkg::SR_SCAN;
                end
            end
            kptm_pkg::SR_SCAN: begin
                if (hit) begin
                    state_next = kptm_pkg::SR_KEY_RD;
                end else if (miss_all) begin
                    state_next = kptm_pkg::SR_RESULT;
                end
            end
            kptm_pkg::SR_RESULT: begin
                if (out_free) begin
                    state_next = kptm_pkg::SR_IDLE;
                end
            end
            kptm_pkg::SR_KEY_RD: begin
                state_next = kptm_pkg::SR_KEY_WR;
            end
            kptm_pkg::SR_KEY_WR: begin
                if (out_free) begin
                    state_next = key_last ? kptm_pkg::SR_IDLE : kptm_pkg::SR_KEY_RD;
                end
            end
            default: begin
                state_next = kptm_pkg::SR_IDLE;
            end
        endcase
    end

    always_comb begin
        scan_entry_next  = scan_entry_reg;
        scan_word_next   = scan_word_reg;
        issue_on_next    = issue_on_reg;
        cmp_valid_next   = 1'b0;
        cmp_entry_next   = scan_entry_reg;
        cmp_word_next    = scan_word_reg;
        cmp_final_next   = scan_last_entry;
        same_next        = cmp_valid_reg ? same_now : same_reg;
        match_entry_next = match_entry_reg;
        key_idx_next     = key_idx_reg;
        mrd_en           = 1'b0;
        mrd_addr         = {scan_entry_reg, scan_word_reg};
        krd_en           = 1'b0;
        krd_addr         = {match_entry_reg, key_idx_reg};
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_index_next     = m_index_reg;
        m_key_next       = m_key_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            kptm_pkg::SR_IDLE: begin
                // The request side only ends a request when the result
                // register is free, so single results load at once.
                if (fin.valid) begin
                    m_key_next  = '0;
                    m_last_next = 1'b1;
                    m_index_next = '0;
                    if (!fin.is_match) begin
                        m_valid_next  = 1'b1;
                        m_status_next = fin.full ? kptm_pkg::STAT_FULL : kptm_pkg::STAT_ADDED;
                        m_index_next  = fin.full ? '0 : kptm_pkg::INDEX_W'(fin.entry);
                    end else if (!fin.att_ok) begin
                        m_valid_next  = 1'b1;
                        m_status_next = kptm_pkg::STAT_BAD_ATT;
                    end else if (entry_count == '0) begin
                        m_valid_next  = 1'b1;
                        m_status_next = kptm_pkg::STAT_NO_MATCH;
                    end
                end
                scan_entry_next = '0;
                scan_word_next  = '0;
                issue_on_next   = start_scan;
                key_idx_next    = '0;
            end
            kptm_pkg::SR_SCAN: begin
                // One memory word a cycle; the read in flight when a hit
                // resolves is simply dropped.
                mrd_en = issue_on_reg;
                if (issue_on_reg) begin
                    cmp_valid_next = !hit;
                    if (scan_word_reg == kptm_pkg::MWORD_W'(kptm_pkg::CMP_WORDS - 1)) begin
                        scan_word_next  = '0;
                        scan_entry_next = scan_entry_reg + 1'b1;
                        if (scan_last_entry) begin
                            issue_on_next = 1'b0;
                        end
                    end else begin
                        scan_word_next = scan_word_reg + 1'b1;
                    end
                end
                if (hit || miss_all) begin
                    issue_on_next  = 1'b0;
                    cmp_valid_next = 1'b0;
                end
                if (hit) begin
                    match_entry_next = cmp_entry_reg;
                end
            end
            kptm_pkg::SR_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = kptm_pkg::STAT_NO_MATCH;
                    m_index_next  = '0;
                    m_key_next    = '0;
                    m_last_next   = 1'b1;
                end
            end
            kptm_pkg::SR_KEY_RD: begin
                krd_en = 1'b1;
            end
            kptm_pkg::SR_KEY_WR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = kptm_pkg::STAT_MATCH;
                    m_index_next  = kptm_pkg::INDEX_W'(match_entry_reg);
                    m_key_next    = krd_data;
                    m_last_next   = key_last;
                    key_idx_next  = key_idx_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kptm_pkg::SR_IDLE;
            issue_on_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_on_reg  <= issue_on_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_entry_reg  <= scan_entry_next;
        scan_word_reg   <= scan_word_next;
        cmp_entry_reg   <= cmp_entry_next;
        cmp_word_reg    <= cmp_word_next;
        cmp_final_reg   <= cmp_final_next;
        same_reg        <= same_next;
        match_entry_reg <= match_entry_next;
        key_idx_reg     <= key_idx_next;
        m_status_reg    <= m_status_next;
        m_index_reg     <= m_index_next;
        m_key_reg       <= m_key_next;
        m_last_reg      <= m_last_next;
    end

    assign ctl.idle     = (state_reg == kptm_pkg::SR_IDLE);
    assign ctl.out_free = out_free;
    assign m_tvalid     = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_index      = m_index_reg;
    assign m_key        = m_key_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

### hw/rtl/key_policy_table_match.sv
// ----------------------------------------------------------------------------
// key_policy_table_match
// Policy table of key id, measure and key entries with append and
// first-match lookup over a 64-bit word stream.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata                             tuser       tlast
//  s_       in         [63:0] data_word                  [0] action  -
//  m_       out        [4:0] entry_index, [68:5] key     [2:0] status last
//
// One request word is taken per cycle while the search side is idle. An add
// request ends with its result in the cycle after its last word. A match
// request takes its words, then a scan of the match memory at one word per
// cycle through its single read port, then a readout of each key word in turn.
// No new request word is taken during a scan or key readout.
// Reset clears the entry count and the control state only; the memories
// need no clearing pass, since entries at or above the count are never read.
// A stalled result holds in the output register; the request side keeps
// taking words until a request would need that register while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module key_policy_table_match (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [kptm_pkg::S_TDATA_W-1:0]    s_tdata,   // [63:0] data_word
    input  wire logic [0:0]                        s_tuser,   // [0] action
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [kptm_pkg::M_TDATA_W-1:0]    m_tdata,   // [4:0] entry_index,
                                                              // [68:5] key_word
    output logic      [kptm_pkg::STATUS_W-1:0]     m_tuser,   // [2:0] status
    output logic                                   m_tlast
);

    kptm_pkg::ctl_t                 ctl;
    kptm_pkg::fin_t                 fin;
    kptm_pkg::req_words_t           req_words;
    kptm_pkg::status_t              m_status;
    logic [kptm_pkg::COUNT_W-1:0]   entry_count;
    logic                           mwr_en;
    logic [kptm_pkg::MADDR_W-1:0]   mwr_addr;
    logic                           kwr_en;
    logic [kptm_pkg::KADDR_W-1:0]   kwr_addr;
    logic [kptm_pkg::WORD_W-1:0]    wr_data;
    logic                           mrd_en;
    logic [kptm_pkg::MADDR_W-1:0]   mrd_addr;
    logic [kptm_pkg::WORD_W-1:0]    mrd_data;
    logic                           krd_en;
    logic [kptm_pkg::KADDR_W-1:0]   krd_addr;
    logic [kptm_pkg::WORD_W-1:0]    krd_data;
    logic [kptm_pkg::INDEX_W-1:0]   m_index;
    logic [kptm_pkg::WORD_W-1:0]    m_key;
    logic                           m_last_int;

    kptm_ingest u_ingest (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_action    (s_tuser[0]),
        .s_word      (s_tdata),
        .ctl         (ctl),
        .fin         (fin),
        .entry_count (entry_count),
        .req_words   (req_words),
        .mwr_en      (mwr_en),
        .mwr_addr    (mwr_addr),
        .kwr_en      (kwr_en),
        .kwr_addr    (kwr_addr),
        .wr_data     (wr_data)
    );

    // Key id and measure words of each entry.
    kptm_ram #(
        .WIDTH  (kptm_pkg::WORD_W),
        .ADDR_W (kptm_pkg::MADDR_W)
    ) u_match_ram (
        .aclk    (aclk),
        .wr_en   (mwr_en),
        .wr_addr (mwr_addr),
        .wr_data (wr_data),
        .rd_en   (mrd_en),
        .rd_addr (mrd_addr),
        .rd_data (mrd_data)
    );

    // Key words of each entry.
    kptm_ram #(
        .WIDTH  (kptm_pkg::WORD_W),
        .ADDR_W (kptm_pkg::KADDR_W)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (kwr_en),
        .wr_addr (kwr_addr),
        .wr_data (wr_data),
        .rd_en   (krd_en),
        .rd_addr (krd_addr),
        .rd_data (krd_data)
    );

    kptm_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fin         (fin),
        .entry_count (entry_count),
        .req_words   (req_words),
        .mrd_en      (mrd_en),
        .mrd_addr    (mrd_addr),
        .mrd_data    (mrd_data),
        .krd_en      (krd_en),
        .krd_addr    (krd_addr),
        .krd_data    (krd_data),
        .ctl         (ctl),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (m_status),
        .m_index     (m_index),
        .m_key       (m_key),
        .m_last      (m_last_int)
    );

    assign m_tdata = {{kptm_pkg::M_PAD_W{1'b0}}, m_key, m_index};
    assign m_tuser = m_status;
    assign m_tlast = m_last_int;

    // A request may only end while the result register can take its result.
    `ASSERT_IMPL(a_fin_out_free, aclk, aresetn, fin.valid, ctl.out_free)
    // The entry count never passes the table depth.
    `ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, entry_count <= kptm_pkg::COUNT_W'(kptm_pkg::TABLE_DEPTH))
    // Only a key readout gives a result that is not the last of its request.
    `ASSERT_IMPL(a_run_is_match, aclk, aresetn, m_tvalid && !m_tlast, m_tuser == kptm_pkg::STAT_MATCH)
    // A match request that starts a scan stops further request words.
    `ASSERT_NEXT(a_scan_blocks, aclk, aresetn, fin.valid && fin.is_match && fin.att_ok && entry_count != '0, !s_tready)

endmodule

`default_nettype wire
